// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the tokenizer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define ASSERT_AT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Expression that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);

`endif

// ===== rtl/core/ctok_pkg.sv =====
// Types, token codes and keyword table of the C subset tokenizer.
package ctok_pkg;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_end;
  } ctok_in_t;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [2:0]  keyword_index;
    logic [15:0] token_row;
    logic [15:0] token_col;
    logic [15:0] token_length;
    logic [63:0] token_head;
    logic        last;
  } ctok_out_t;

  // Up to two results leave the scanner per byte, first one in the first slot.
  typedef struct packed {
    logic [1:0] cnt;
    ctok_out_t  first;
    ctok_out_t  second;
  } ctok_push_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] idx;
  } ctok_kw_t;

  localparam logic [3:0] KIND_IDENT   = 4'd0;
  localparam logic [3:0] KIND_KEYWORD = 4'd1;
  localparam logic [3:0] KIND_LPAREN  = 4'd2;
  localparam logic [3:0] KIND_RPAREN  = 4'd3;
  localparam logic [3:0] KIND_LBRACE  = 4'd4;
  localparam logic [3:0] KIND_RBRACE  = 4'd5;
  localparam logic [3:0] KIND_COMMA   = 4'd6;
  localparam logic [3:0] KIND_ASSIGN  = 4'd7;
  localparam logic [3:0] KIND_SEMI    = 4'd8;
  localparam logic [3:0] KIND_STRING  = 4'd9;

  localparam logic [15:0] SAT16 = 16'hFFFF;

  // Result queue depth; must be a power of two.
  localparam int OQ_DEPTH = 8;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = OQ_PTR_W + 1;

  localparam int KW_NUM = 5;
  // Keyword text packed first byte lowest: int, main, printf, char, return.
  localparam logic [63:0] KW_TEXT [KW_NUM] = '{
    64'h0000_0000_0074_6E69,
    64'h0000_0000_6E69_616D,
    64'h0000_6674_6E69_7270,
    64'h0000_0000_7261_6863,
    64'h0000_6E72_7574_6572
  };
  localparam logic [15:0] KW_LEN [KW_NUM] = '{16'd3, 16'd4, 16'd6, 16'd4, 16'd6};

  // Bytes above the lexeme length are always zero, so a whole-word compare suffices.
  function automatic ctok_kw_t kw_lookup(input logic [63:0] head, input logic [15:0] len);
    ctok_kw_t res;
    res = '0;
    for (int k = KW_NUM - 1; k >= 0; k--) begin
      if (len == KW_LEN[k] && head == KW_TEXT[k]) begin
        res.hit = 1'b1;
        res.idx = 3'(k);
      end
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/c_subset_tokenizer.sv =====
// Top level of the C subset tokenizer: input register, scanner and result queue.
//
//   channel  direction  payload                 handshake
//   in_      in         ctok_in_t  (ch, is_end)  in_valid / in_stall
//   out_     out        ctok_out_t (one token)   out_valid / out_stall
//
// One source byte is taken per cycle while in_stall is low. An accepted byte is
// held in the input register, the scanner writes its tokens into the result
// queue memory, and the queue moves its oldest token into its output register,
// from which it is taken when out_stall is low.
// A byte that ends an identifier and is itself a token gives two tokens, and the
// queue takes both at once; the output gives one token per cycle unless stalled.
// in_stall rises only when the queue could not take two more tokens for each
// byte in flight, which happens when the output side has been stalled.
// Reset (rst_n low, synchronous) empties the queue and returns the scanner to
// normal scanning at row 1, column 1; no clearing pass is needed.
//
// Token position counters and lexeme length saturate at 65535; the head keeps
// the first HEAD_BYTES bytes of a lexeme.
module c_subset_tokenizer #(
  parameter int HEAD_BYTES = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ctok_pkg::ctok_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ctok_pkg::ctok_out_t out_data
);

  localparam int FILL_W = ctok_pkg::OQ_CNT_W + 1;

  logic                          inq_valid_r, inq_valid_nxt;
  ctok_pkg::ctok_in_t            inq_r;
  ctok_pkg::ctok_push_t          push;
  logic [ctok_pkg::OQ_CNT_W-1:0] oq_cnt;
  logic [FILL_W-1:0]             fill;
  logic                          in_take;
  logic                          pop;

  // Worst case the pending byte adds two tokens; a new byte must still find
  // room for its own two afterwards.
  assign fill     = {1'b0, oq_cnt} + (inq_valid_r ? FILL_W'(2) : FILL_W'(0));
  assign in_stall = fill > FILL_W'(ctok_pkg::OQ_DEPTH - 2);
  assign in_take  = in_valid && !in_stall;
  assign inq_valid_nxt = in_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_valid_r <= 1'b0;
    end else begin
      inq_valid_r <= inq_valid_nxt;
    end
  end

  // The payload register loads only on a transaction.
  always_ff @(posedge clk) begin
    if (in_take) inq_r <= in_data;
  end

  ctok_scan #(
    .HEAD_BYTES (HEAD_BYTES)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (inq_valid_r),
    .item       (inq_r),
    .push       (push)
  );

  assign pop = out_valid && !out_stall;

  ctok_oq u_oq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop        (pop),
    .head       (out_data),
    .head_valid (out_valid),
    .cnt        (oq_cnt)
  );

endmodule

// ===== rtl/core/ctok_scan.sv =====
// Scanner: lexer state registers and the per-byte next-state and result logic.
`include "assert_macros.svh"

module ctok_scan #(
  parameter int HEAD_BYTES = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_valid,
  input  ctok_pkg::ctok_in_t item,
  output ctok_pkg::ctok_push_t push
);

  localparam logic [2:0] M_NORMAL = 3'd0;
  localparam logic [2:0] M_IDENT  = 3'd1;
  localparam logic [2:0] M_HASH   = 3'd2;
  localparam logic [2:0] M_SLASH  = 3'd3;
  localparam logic [2:0] M_LINE   = 3'd4;
  localparam logic [2:0] M_BLOCK  = 3'd5;
  localparam logic [2:0] M_STAR   = 3'd6;
  localparam logic [2:0] M_STRING = 3'd7;

  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  logic [2:0]  mode_r, mode_nxt;
  logic [63:0] head_r, head_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] line_r, line_nxt;
  logic [15:0] col_r, col_nxt;
  logic [15:0] srow_r, srow_nxt;
  logic [15:0] scol_r, scol_nxt;

  logic [7:0]  c;
  logic        alpha;
  logic [2:0]  nrm_mode;
  logic        nrm_begin;
  logic        nrm_tok;
  logic [3:0]  nrm_kind;
  logic [63:0] app_head;
  logic [15:0] app_len;
  ctok_pkg::ctok_kw_t  kw;
  ctok_pkg::ctok_out_t id_res;
  ctok_pkg::ctok_out_t tok_res;
  ctok_pkg::ctok_out_t r0, r1;
  logic        r0_v, r1_v;
  logic        use_normal;

  assign c     = item.ch;
  assign alpha = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);

  // Decode of a byte met in normal scanning.
  always_comb begin
    nrm_mode  = M_NORMAL;
    nrm_begin = 1'b0;
    nrm_tok   = 1'b0;
    nrm_kind  = ctok_pkg::KIND_IDENT;
    case (c)
      CH_HASH:   nrm_mode = M_HASH;
      CH_SLASH:  nrm_mode = M_SLASH;
      CH_QUOTE: begin
        nrm_mode  = M_STRING;
        nrm_begin = 1'b1;
      end
      CH_LPAREN: begin nrm_tok = 1'b1; nrm_kind = ctok_pkg::KIND_LPAREN; end
      CH_RPAREN: begin nrm_tok = 1'b1; nrm_kind = ctok_pkg::KIND_RPAREN; end
      CH_LBRACE: begin nrm_tok = 1'b1; nrm_kind = ctok_pkg::KIND_LBRACE; end
      CH_RBRACE: begin nrm_tok = 1'b1; nrm_kind = ctok_pkg::KIND_RBRACE; end
      CH_COMMA:  begin nrm_tok = 1'b1; nrm_kind = ctok_pkg::KIND_COMMA; end
      CH_EQ:     begin nrm_tok = 1'b1; nrm_kind = ctok_pkg::KIND_ASSIGN; end
      CH_SEMI:   begin nrm_tok = 1'b1; nrm_kind = ctok_pkg::KIND_SEMI; end
      default: begin
        if (alpha) begin
          nrm_mode  = M_IDENT;
          nrm_begin = 1'b1;
        end
      end
    endcase
  end

  // Appending a byte: it lands in the head only while the head has room.
  always_comb begin
    app_head = head_r;
    for (int i = 0; i < 8; i++) begin
      if (i < HEAD_BYTES && len_r == 16'(i)) begin
        app_head[8*i +: 8] = c;
      end
    end
    app_len = (len_r != ctok_pkg::SAT16) ? len_r + 16'd1 : len_r;
  end

  always_comb begin
    kw = ctok_pkg::kw_lookup(head_r, len_r);
    id_res               = '0;
    id_res.token_kind    = kw.hit ? ctok_pkg::KIND_KEYWORD : ctok_pkg::KIND_IDENT;
    id_res.keyword_index = kw.hit ? kw.idx : 3'd0;
    id_res.token_row     = srow_r;
    id_res.token_col     = scol_r;
    id_res.token_length  = len_r;
    id_res.token_head    = head_r;

    tok_res              = '0;
    tok_res.token_kind   = nrm_kind;
    tok_res.token_row    = line_r;
    tok_res.token_col    = col_r;
    tok_res.token_length = 16'd1;
    tok_res.token_head   = {56'd0, c};
  end

  always_comb begin
    mode_nxt   = mode_r;
    head_nxt   = head_r;
    len_nxt    = len_r;
    line_nxt   = line_r;
    col_nxt    = col_r;
    srow_nxt   = srow_r;
    scol_nxt   = scol_r;
    r0         = '0;
    r1         = '0;
    r0_v       = 1'b0;
    r1_v       = 1'b0;
    use_normal = 1'b0;

    if (item_valid) begin
      if (item.is_end) begin
        if (mode_r == M_IDENT) begin
          r0   = id_res;
          r0_v = 1'b1;
        end
        mode_nxt = M_NORMAL;
        head_nxt = '0;
        len_nxt  = '0;
        line_nxt = 16'd1;
        col_nxt  = 16'd1;
        srow_nxt = '0;
        scol_nxt = '0;
      end else begin
        case (mode_r)
          M_IDENT: begin
            if (alpha) begin
              head_nxt = app_head;
              len_nxt  = app_len;
            end else begin
              r0         = id_res;
              r0_v       = 1'b1;
              use_normal = 1'b1;
            end
          end
          M_HASH, M_LINE: begin
            if (c == CH_LF) mode_nxt = M_NORMAL;
          end
          M_SLASH: begin
            if (c == CH_SLASH) mode_nxt = M_LINE;
            else if (c == CH_STAR) mode_nxt = M_BLOCK;
            else use_normal = 1'b1;
          end
          M_BLOCK: begin
            if (c == CH_STAR) mode_nxt = M_STAR;
          end
          M_STAR: begin
            if (c == CH_SLASH) mode_nxt = M_NORMAL;
            else if (c != CH_STAR) mode_nxt = M_BLOCK;
          end
          M_STRING: begin
            head_nxt = app_head;
            len_nxt  = app_len;
            if (c == CH_QUOTE) begin
              r0              = '0;
              r0.token_kind   = ctok_pkg::KIND_STRING;
              r0.token_row    = srow_r;
              r0.token_col    = scol_r;
              r0.token_length = app_len;
              r0.token_head   = app_head;
              r0_v            = 1'b1;
              mode_nxt        = M_NORMAL;
            end
          end
          default: use_normal = 1'b1;
        endcase

        if (use_normal) begin
          mode_nxt = nrm_mode;
          if (nrm_begin) begin
            head_nxt = {56'd0, c};
            len_nxt  = 16'd1;
            srow_nxt = line_r;
            scol_nxt = col_r;
          end
          if (nrm_tok) begin
            if (r0_v) begin
              r1   = tok_res;
              r1_v = 1'b1;
            end else begin
              r0   = tok_res;
              r0_v = 1'b1;
            end
          end
        end

        if (c == CH_LF) begin
          if (line_r != ctok_pkg::SAT16) line_nxt = line_r + 16'd1;
          col_nxt = 16'd1;
        end else if (col_r != ctok_pkg::SAT16) begin
          col_nxt = col_r + 16'd1;
        end
      end
    end
  end

  always_comb begin
    push             = '0;
    push.cnt         = r1_v ? 2'd2 : (r0_v ? 2'd1 : 2'd0);
    push.first       = r0;
    push.first.last  = r0_v && !r1_v;
    push.second      = r1;
    push.second.last = r1_v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_NORMAL;
      head_r <= '0;
      len_r  <= '0;
      line_r <= 16'd1;
      col_r  <= 16'd1;
      srow_r <= '0;
      scol_r <= '0;
    end else begin
      mode_r <= mode_nxt;
      head_r <= head_nxt;
      len_r  <= len_nxt;
      line_r <= line_nxt;
      col_r  <= col_nxt;
      srow_r <= srow_nxt;
      scol_r <= scol_nxt;
    end
  end

  `ASSERT_AT_CLK(a_end_resets_position, clk, rst_n,
    (item_valid && item.is_end) |=> (line_r == 16'd1 && col_r == 16'd1),
    "end marker did not return the position to row 1, column 1")
  `ASSERT_AT_CLK(a_pair_starts_with_ident, clk, rst_n,
    (push.cnt == 2'd2) |-> (push.first.token_kind == ctok_pkg::KIND_IDENT ||
                            push.first.token_kind == ctok_pkg::KIND_KEYWORD),
    "two results from one byte without a flushed identifier first")

endmodule

// ===== rtl/core/ctok_oq.sv =====
// Result queue: takes up to two tokens per cycle and presents one per cycle from a register while it is popped.
`include "assert_macros.svh"

module ctok_oq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ctok_pkg::ctok_push_t          push,
  input  logic                          pop,
  output ctok_pkg::ctok_out_t           head,
  output logic                          head_valid,
  output logic [ctok_pkg::OQ_CNT_W-1:0] cnt
);

  ctok_pkg::ctok_out_t mem [ctok_pkg::OQ_DEPTH];

  logic [ctok_pkg::OQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [ctok_pkg::OQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [ctok_pkg::OQ_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [ctok_pkg::OQ_PTR_W-1:0] wr_ptr_p1;
  ctok_pkg::ctok_out_t           head_r;
  logic                          head_v_r, head_v_nxt;
  logic                          load;

  // The output register refills from the memory whenever it is empty or being emptied.
  assign load       = (cnt_r != '0) && (!head_v_r || pop);
  assign wr_ptr_p1  = wr_ptr_r + ctok_pkg::OQ_PTR_W'(1);
  assign wr_ptr_nxt = wr_ptr_r + ctok_pkg::OQ_PTR_W'(push.cnt);
  assign rd_ptr_nxt = rd_ptr_r + ctok_pkg::OQ_PTR_W'(load);
  assign cnt_nxt    = cnt_r + ctok_pkg::OQ_CNT_W'(push.cnt) - ctok_pkg::OQ_CNT_W'(load);
  assign head_v_nxt = load || (head_v_r && !pop);

  assign head       = head_r;
  assign head_valid = head_v_r;
  assign cnt        = cnt_r;

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) mem[wr_ptr_r] <= push.first;
    if (push.cnt == 2'd2) mem[wr_ptr_p1] <= push.second;
    if (load) head_r <= mem[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      head_v_r <= 1'b0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
      head_v_r <= head_v_nxt;
    end
  end

  `ASSERT_NEVER(a_oq_overflow, clk, rst_n,
    ({1'b0, cnt_r} + (ctok_pkg::OQ_CNT_W + 1)'(push.cnt)) >
      (ctok_pkg::OQ_CNT_W + 1)'(ctok_pkg::OQ_DEPTH),
    "result queue written beyond its depth")
  `ASSERT_NEVER(a_oq_pop_empty, clk, rst_n,
    pop && !head_v_r,
    "result taken while the output register was empty")

endmodule

// ===== tb/ctok_scoreboard.sv =====
// Scoreboard for the C subset tokenizer: predicts tokens from accepted bytes and checks results.
module ctok_scoreboard #(
  parameter int HEAD_BYTES = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  ctok_pkg::ctok_in_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  ctok_pkg::ctok_out_t out_data,
  output int                  fail_count,
  output int                  tokens_pending
);
  import ctok_pkg::*;

  typedef enum logic [2:0] {
    SCAN_NORMAL, SCAN_IDENT, SCAN_HASH, SCAN_SLASH,
    SCAN_LINE, SCAN_BLOCK, SCAN_STAR, SCAN_STRING
  } scan_mode_e;

  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_ASSIGN = 8'h3D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  scan_mode_e  mode;
  logic [63:0] lex_head;
  logic [15:0] lex_len;
  logic [15:0] line_no;
  logic [15:0] col_no;
  logic [15:0] tok_row;
  logic [15:0] tok_col;

  ctok_out_t expected_tokens[$];
  ctok_out_t step_tokens[$];

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic string keyword_spelling(input int k);
    case (k)
      0: return "int";
      1: return "main";
      2: return "printf";
      3: return "char";
      default: return "return";
    endcase
  endfunction

  task automatic reset_scanner();
    mode     = SCAN_NORMAL;
    lex_head = '0;
    lex_len  = '0;
    line_no  = 16'd1;
    col_no   = 16'd1;
    tok_row  = '0;
    tok_col  = '0;
  endtask

  task automatic note_token(input logic [3:0] kind, input logic [2:0] kw,
                            input logic [15:0] row, input logic [15:0] col,
                            input logic [15:0] len, input logic [63:0] head);
    ctok_out_t t;
    t.token_kind    = kind;
    t.keyword_index = kw;
    t.token_row     = row;
    t.token_col     = col;
    t.token_length  = len;
    t.token_head    = head;
    t.last          = 1'b0;
    step_tokens.push_back(t);
  endtask

  task automatic start_lexeme(input logic [7:0] c);
    lex_head = 64'(c);
    lex_len  = 16'd1;
    tok_row  = line_no;
    tok_col  = col_no;
  endtask

  task automatic grow_lexeme(input logic [7:0] c);
    if (lex_len < HEAD_BYTES) lex_head[8*int'(lex_len) +: 8] = c;
    if (lex_len != SAT16) lex_len = lex_len + 16'd1;
  endtask

  // An identifier is a keyword only when its length and every byte agree.
  task automatic close_word();
    string       s;
    logic        same;
    logic [3:0]  kind;
    logic [2:0]  idx;
    kind = KIND_IDENT;
    idx  = '0;
    for (int k = 0; k < 5; k++) begin
      s    = keyword_spelling(k);
      same = (int'(lex_len) == s.len());
      for (int i = 0; same && i < s.len(); i++)
        if (lex_head[8*i +: 8] != s[i]) same = 1'b0;
      if (same && kind == KIND_IDENT) begin
        kind = KIND_KEYWORD;
        idx  = 3'(k);
      end
    end
    note_token(kind, idx, tok_row, tok_col, lex_len, lex_head);
    mode = SCAN_NORMAL;
  endtask

  task automatic scan_plain(input logic [7:0] c);
    logic [3:0] kind;
    if (is_letter(c)) begin
      start_lexeme(c);
      mode = SCAN_IDENT;
    end else begin
      kind = KIND_IDENT;
      case (c)
        CH_HASH:   mode = SCAN_HASH;
        CH_SLASH:  mode = SCAN_SLASH;
        CH_QUOTE: begin
          start_lexeme(c);
          mode = SCAN_STRING;
        end
        CH_LPAREN: kind = KIND_LPAREN;
        CH_RPAREN: kind = KIND_RPAREN;
        CH_LBRACE: kind = KIND_LBRACE;
        CH_RBRACE: kind = KIND_RBRACE;
        CH_COMMA:  kind = KIND_COMMA;
        CH_ASSIGN: kind = KIND_ASSIGN;
        CH_SEMI:   kind = KIND_SEMI;
        default:   ;
      endcase
      if (kind != KIND_IDENT)
        note_token(kind, 3'd0, line_no, col_no, 16'd1, 64'(c));
    end
  endtask

  task automatic predict_tokens(input ctok_in_t item);
    ctok_out_t t;
    logic [7:0] c;
    c = item.ch;
    step_tokens.delete();
    if (item.is_end) begin
      if (mode == SCAN_IDENT) close_word();
      reset_scanner();
    end else begin
      case (mode)
        SCAN_IDENT: begin
          if (is_letter(c)) begin
            grow_lexeme(c);
          end else begin
            close_word();
            scan_plain(c);
          end
        end
        SCAN_HASH, SCAN_LINE: if (c == CH_LF) mode = SCAN_NORMAL;
        SCAN_SLASH: begin
          if (c == CH_SLASH) mode = SCAN_LINE;
          else if (c == CH_STAR) mode = SCAN_BLOCK;
          else begin
            mode = SCAN_NORMAL;
            scan_plain(c);
          end
        end
        SCAN_BLOCK: if (c == CH_STAR) mode = SCAN_STAR;
        SCAN_STAR: begin
          if (c == CH_SLASH) mode = SCAN_NORMAL;
          else if (c != CH_STAR) mode = SCAN_BLOCK;
        end
        SCAN_STRING: begin
          grow_lexeme(c);
          if (c == CH_QUOTE) begin
            note_token(KIND_STRING, 3'd0, tok_row, tok_col, lex_len, lex_head);
            mode = SCAN_NORMAL;
          end
        end
        default: scan_plain(c);
      endcase
      if (c == CH_LF) begin
        if (line_no != SAT16) line_no = line_no + 16'd1;
        col_no = 16'd1;
      end else if (col_no != SAT16) begin
        col_no = col_no + 16'd1;
      end
    end
    for (int i = 0; i < step_tokens.size(); i++) begin
      t      = step_tokens[i];
      t.last = (i == step_tokens.size() - 1);
      expected_tokens.push_back(t);
    end
  endtask

  function automatic int field_diff(input string name, input logic [63:0] want,
                                    input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    ctok_out_t want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      reset_scanner();
      expected_tokens.delete();
    end else begin
      if (in_valid && !in_stall) predict_tokens(in_data);
      if (out_valid && !out_stall) begin
        if (expected_tokens.size() == 0) begin
          $error("token_kind: no token expected, actual 0x%0h", out_data.token_kind);
          errs++;
        end else begin
          want = expected_tokens.pop_front();
          errs += field_diff("token_kind", 64'(want.token_kind), 64'(out_data.token_kind));
          errs += field_diff("keyword_index", 64'(want.keyword_index),
                             64'(out_data.keyword_index));
          errs += field_diff("token_row", 64'(want.token_row), 64'(out_data.token_row));
          errs += field_diff("token_col", 64'(want.token_col), 64'(out_data.token_col));
          errs += field_diff("token_length", 64'(want.token_length),
                             64'(out_data.token_length));
          errs += field_diff("token_head", want.token_head, out_data.token_head);
          errs += field_diff("last", 64'(want.last), 64'(out_data.last));
        end
      end
    end
    fail_count     <= fail_count + errs;
    tokens_pending <= expected_tokens.size();
  end

endmodule

// ===== tb/tb_c_subset_tokenizer.sv =====
// Top of the tokenizer testbench: clock, reset, byte stimulus, result stalls and verdict.
module tb_c_subset_tokenizer;
  import ctok_pkg::*;

  // Bytes of random text to send after the directed text.
  localparam int RANDOM_ITEMS = 1620;
  localparam int CYCLE_LIMIT  = 1_500_000;
  // Extra wait after the last expected token, so that any stray one shows up.
  localparam int DRAIN_CYCLES = 16;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  ctok_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  ctok_out_t out_data;

  // While calm is set, neither side idles, so the block runs at full rate.
  logic      calm      = 1'b1;
  int        stall_run = 0;
  int        cycle_count = 0;
  int        fail_count;
  int        tokens_pending;
  int        text_bytes_sent = 0;
  ctok_in_t  source_text[$];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  c_subset_tokenizer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  ctok_scoreboard scoreboard (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .fail_count     (fail_count),
    .tokens_pending (tokens_pending)
  );

  // The run is abandoned if it has not finished well beyond the slowest correct pace.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // The result side holds its stall setting in runs: mostly short, now and again a long
  // one, which, when it stalls, fills the result queue and pushes back on the byte side.
  always @(posedge clk) begin
    if (!rst_n || calm) begin
      out_stall <= 1'b0;
      stall_run <= 0;
    end else if (stall_run > 0) begin
      stall_run <= stall_run - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 35);
      if ($urandom_range(0, 9) == 0) stall_run <= $urandom_range(15, 40);
      else stall_run <= $urandom_range(0, 3);
    end
  end

  function automatic int idle_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // One byte transaction: the payload is held until the block takes it, and valid
  // only drops when a gap follows, so it is never lowered and raised in one step.
  task automatic send_item(input ctok_in_t item);
    int gap;
    in_data  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic put_byte(input logic [7:0] c);
    ctok_in_t item;
    item.ch     = c;
    item.is_end = 1'b0;
    source_text.push_back(item);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  // The byte that travels with an end marker is ignored, so it is left random.
  task automatic put_end();
    ctok_in_t item;
    item.ch     = 8'($urandom_range(0, 255));
    item.is_end = 1'b1;
    source_text.push_back(item);
  endtask

  task automatic send_text();
    while (source_text.size() > 0) send_item(source_text.pop_front());
  endtask

  function automatic logic [7:0] any_letter();
    int k;
    k = $urandom_range(0, 51);
    return (k < 26) ? 8'(8'h61 + k) : 8'(8'h41 + k - 26);
  endfunction

  function automatic string any_keyword();
    case ($urandom_range(0, 4))
      0: return "int";
      1: return "main";
      2: return "printf";
      3: return "char";
      default: return "return";
    endcase
  endfunction

  // Any byte except the double quote, so that a string only closes where intended.
  function automatic logic [7:0] string_byte();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (c == 8'h22) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  // Appends one piece of source text and returns how many bytes it added.
  task automatic add_fragment(output int frag_bytes);
    int    r;
    int    n;
    int    before_size;
    string punct;
    punct       = "(){},=;";
    before_size = source_text.size();
    r = $urandom_range(0, 99);
    if (r < 25) begin
      // Identifiers: exact keywords, keywords with a tail, and plain words of 1 to 24 letters.
      n = $urandom_range(0, 5);
      if (n < 2) put_text(any_keyword());
      else if (n == 2) begin
        put_text(any_keyword());
        repeat ($urandom_range(1, 3)) put_byte(any_letter());
      end else begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 24) : $urandom_range(1, 10);
        repeat (n) put_byte(any_letter());
      end
    end else if (r < 45) begin
      put_byte(punct[$urandom_range(0, 6)]);
    end else if (r < 58) begin
      case ($urandom_range(0, 2))
        0: put_byte(8'h20);
        1: put_byte(8'h09);
        default: put_byte(8'h0A);
      endcase
    end else if (r < 66) begin
      // Strings, sometimes spanning lines and occasionally left open.
      put_byte(8'h22);
      repeat ($urandom_range(0, 12)) begin
        if ($urandom_range(0, 7) == 0) put_byte(8'h0A);
        else put_byte(string_byte());
      end
      if ($urandom_range(0, 9) != 0) put_byte(8'h22);
    end else if (r < 72) begin
      put_text("//");
      repeat ($urandom_range(0, 8)) begin
        n = $urandom_range(0, 255);
        put_byte((n == 8'h0A) ? 8'h20 : 8'(n));
      end
      put_byte(8'h0A);
    end else if (r < 78) begin
      put_text("/*");
      repeat ($urandom_range(0, 8)) begin
        case ($urandom_range(0, 3))
          0: put_byte(8'h2A);
          1: put_byte(8'h0A);
          default: put_byte(8'($urandom_range(0, 255)));
        endcase
      end
      if ($urandom_range(0, 1) == 0) put_byte(8'h2A);
      if ($urandom_range(0, 9) != 0) put_text("*/");
    end else if (r < 82) begin
      put_byte(8'h23);
      repeat ($urandom_range(0, 6)) put_byte(any_letter());
      put_byte(8'h0A);
    end else if (r < 85) begin
      // A lone slash in front of a token.
      put_byte(8'h2F);
      put_byte(punct[$urandom_range(0, 6)]);
    end else if (r < 97) begin
      put_byte(8'($urandom_range(0, 255)));
    end else begin
      put_end();
    end
    frag_bytes = source_text.size() - before_size;
  endtask

  initial begin
    int calm_left;
    int frag_bytes;
    calm_left = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    calm  <= 1'b0;

    // Directed text: every token kind and keyword, each kind of comment, a hash line,
    // a dropped slash, a string across a newline, the extreme byte values, a long
    // identifier, and an end marker that flushes a pending identifier.
    put_text("#x\n//c\n/*\n**/int main(char,{}=;)");
    put_text("/+printf\"\n\"return ");
    put_byte(8'h00);
    put_byte(8'hFF);
    put_text("returnabcdefghij");
    put_end();
    put_text("\"open");
    put_end();
    put_text("/*");
    put_end();
    put_text("ab");
    put_end();
    send_text();

    // Random text, mostly well formed, with calm stretches now and then.
    while (text_bytes_sent < RANDOM_ITEMS) begin
      if (calm_left > 0) calm_left--;
      else if ($urandom_range(0, 49) == 0) calm_left = $urandom_range(20, 60);
      calm <= (calm_left > 0);
      add_fragment(frag_bytes);
      text_bytes_sent += frag_bytes;
      send_text();
    end

    // Wait for every predicted token to arrive, then a little longer for strays.
    in_valid <= 1'b0;
    calm     <= 1'b0;
    do @(posedge clk); while (tokens_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && tokens_pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== c_subset_tokenizer.f =====
+incdir+rtl/core
rtl/core/ctok_pkg.sv
rtl/core/ctok_scan.sv
rtl/core/ctok_oq.sv
rtl/core/c_subset_tokenizer.sv
tb/ctok_scoreboard.sv
tb/tb_c_subset_tokenizer.sv
